// ----- rtl/core/ffa_pkg.sv -----
`timescale 1ns / 1ps

package ffa_pkg;

    localparam logic [1:0] REQ_FILL    = 2'd0;
    localparam logic [1:0] REQ_WRITE   = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;
    localparam logic [1:0] REQ_ADVANCE = 2'd3;

    localparam logic [1:0] CFG_WIDTH = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SEED = 2'd2;

    localparam logic [1:0] PAT_ASH = 2'd0;
    localparam logic [1:0] PAT_YOUNG = 2'd1;
    localparam logic [1:0] PAT_CORNER = 2'd2;
    localparam logic [1:0] PAT_TENTH = 2'd3;

    localparam logic [2:0] CELL_ASH = 3'd0;
    localparam logic [2:0] CELL_YOUNG = 3'd1;
    localparam logic [2:0] CELL_OLD = 3'd2;
    localparam logic [2:0] CELL_IGNITE = 3'd3;
    localparam logic [2:0] CELL_BURN = 3'd4;
    localparam logic [2:0] CELL_DYING = 3'd5;

    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    localparam logic [31:0] LIM_5 = 32'd858993459;
    localparam logic [31:0] LIM_10 = 32'd429496729;
    localparam logic [31:0] LIM_50 = 32'd85899345;
    localparam logic [31:0] LIM_100 = 32'd42949672;
    localparam logic [31:0] LIM_200 = 32'd21474836;
    localparam logic [31:0] LIM_1000 = 32'd4294967;
    localparam logic [31:0] LIM_20000 = 32'd214748;

    typedef struct packed {
        logic ign;
        logic burn;
        logic dying;
        logic old5;
    } nbr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_ACCESS,
        ST_ACC_CAP,
        ST_GEN_RD,
        ST_GEN_CAP,
        ST_GEN_START,
        ST_GEN_WAIT,
        ST_RESP
    } state_t;

endpackage

// ----- rtl/core/ffa_rule_unit.sv -----
`timescale 1ns / 1ps

module ffa_rule_unit
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             seed_load,
    input  logic [31:0]      seed_value,
    input  logic             start,
    input  logic [2:0]       centre_cell,
    input  ffa_pkg::nbr_t    nbr,
    output logic             done,
    output logic [2:0]       result
);

    logic [31:0]   lfsr_reg, lfsr_next, lfsr_step;
    logic          busy_reg, busy_next;
    logic [1:0]    stage_reg, stage_next;
    logic [2:0]    cell_reg, cell_next;
    ffa_pkg::nbr_t nbr_reg, nbr_next;
    logic          done_reg, done_next;
    logic [2:0]    result_reg, result_next;
    logic          en, last, hit;
    logic [31:0]   limit;
    logic [2:0]    hit_val, miss_val;

    assign lfsr_step = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? ffa_pkg::LFSR_MASK : 32'd0);
    assign hit = lfsr_step < limit;

    always_comb
    begin
        en = 1'b1;
        last = 1'b1;
        limit = ffa_pkg::LIM_1000;
        hit_val = ffa_pkg::CELL_YOUNG;
        miss_val = ffa_pkg::CELL_ASH;
        case (cell_reg)
            ffa_pkg::CELL_YOUNG, ffa_pkg::CELL_OLD:
            begin
                last = stage_reg == 2'd3;
                hit_val = ffa_pkg::CELL_IGNITE;
                miss_val = cell_reg;
                case (stage_reg)
                    2'd0:
                    begin
                        en = nbr_reg.ign;
                        limit = (cell_reg == ffa_pkg::CELL_OLD) ? ffa_pkg::LIM_10
                                                                 : ffa_pkg::LIM_100;
                    end
                    2'd1:
                    begin
                        en = nbr_reg.burn;
                        limit = (cell_reg == ffa_pkg::CELL_OLD) ? ffa_pkg::LIM_5
                                                                 : ffa_pkg::LIM_50;
                    end
                    2'd2:
                    begin
                        en = nbr_reg.dying;
                        limit = (cell_reg == ffa_pkg::CELL_OLD) ? ffa_pkg::LIM_10
                                                                 : ffa_pkg::LIM_100;
                    end
                    default:
                    begin
                        if (cell_reg == ffa_pkg::CELL_OLD)
                        begin
                            en = nbr_reg.old5;
                            limit = ffa_pkg::LIM_20000;
                        end
                        else
                        begin
                            limit = ffa_pkg::LIM_200;
                            hit_val = ffa_pkg::CELL_OLD;
                        end
                    end
                endcase
            end
            ffa_pkg::CELL_IGNITE:
            begin
                limit = ffa_pkg::LIM_10;
                hit_val = ffa_pkg::CELL_BURN;
                miss_val = ffa_pkg::CELL_IGNITE;
            end
            ffa_pkg::CELL_BURN:
            begin
                limit = ffa_pkg::LIM_10;
                hit_val = ffa_pkg::CELL_DYING;
                miss_val = ffa_pkg::CELL_BURN;
            end
            ffa_pkg::CELL_DYING:
            begin
                limit = ffa_pkg::LIM_10;
                hit_val = ffa_pkg::CELL_ASH;
                miss_val = ffa_pkg::CELL_DYING;
            end
            default:
            begin
                limit = ffa_pkg::LIM_1000;
            end
        endcase
    end

    always_comb
    begin
        lfsr_next = lfsr_reg;
        busy_next = busy_reg;
        stage_next = stage_reg;
        cell_next = cell_reg;
        nbr_next = nbr_reg;
        done_next = 1'b0;
        result_next = result_reg;
        if (seed_load)
        begin
            lfsr_next = (seed_value == 32'd0) ? 32'd1 : seed_value;
        end
        else if (start)
        begin
            busy_next = 1'b1;
            stage_next = 2'd0;
            cell_next = centre_cell;
            nbr_next = nbr;
        end
        else if (busy_reg)
        begin
            if (en)
            begin
                lfsr_next = lfsr_step;
            end
            if (en && hit)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                result_next = hit_val;
            end
            else if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                result_next = miss_val;
            end
            else
            begin
                stage_next = stage_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= 32'd1;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
        cell_reg <= cell_next;
        nbr_reg <= nbr_next;
        result_reg <= result_next;
    end

    assign done = done_reg;
    assign result = result_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("rule result without a pending cell");
    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != 32'd0)
        else $error("random register reached zero");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("rule unit restarted while busy");

endmodule

// ----- rtl/core/forest_fire_automaton_engine.sv -----
`timescale 1ns / 1ps
// Fill writes the grid one cell at a time; write and read address one cell, and read
// captures its value in a further state. Advance reads each cell's neighbourhood one
// cell at a time through the single grid read port, starts the rule unit and waits while
// it draws, then writes the new state to the other bank. One request at a time; the next
// is taken once the word has gone to the output register. Reset clears control, sets 64
// by 64, bank a current and the random register to 1; the grid is undefined until written.

module forest_fire_automaton_engine
#(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic [2:0]  cell_value,
    input  logic [1:0]  fill_pattern,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  cell_state,
    output logic [0:0]  status
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = $clog2(DEPTH);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    ffa_pkg::state_t state_reg, state_next;
    logic [6:0]      w_reg, w_next, h_reg, h_next;
    logic            bank_reg, bank_next;
    logic [XW-1:0]   x_reg, x_next;
    logic [YW-1:0]   y_reg, y_next;
    logic [1:0]      dx_reg, dx_next, dy_reg, dy_next;
    logic [1:0]      req_reg, req_next, pat_reg, pat_next;
    logic [2:0]      val_reg, val_next;
    logic [2:0]      centre_reg, centre_next;
    logic [3:0]      olds_reg, olds_next;
    ffa_pkg::nbr_t   nbr_reg, nbr_next;
    logic [2:0]      res_state_reg, res_state_next;
    logic            res_status_reg, res_status_next;
    logic            out_valid_reg, out_valid_next;
    logic [2:0]      out_state_reg, out_state_next;
    logic            out_status_reg, out_status_next;

    logic [2:0]      mem [0:2*DEPTH-1];
    logic [2:0]      rdata_reg;
    logic [AW:0]     raddr, waddr;
    logic            we;
    logic [2:0]      wdata;

    logic [8:0]      w9, h9, tw9, th9, x9, y9, cx9, cy9;
    logic [16:0]     tw_prod, th_prod;
    logic            multi, x_last, y_last, nbr_ok, centre, k_last;
    logic [XW-1:0]   nx;
    logic [YW-1:0]   ny;
    logic            in_acc, rule_start, rule_done, seed_load;
    logic [2:0]      rule_result, fill_val;

    assign w9 = (w_reg == 7'd0) ? 9'd1
              : ({2'b0, w_reg} > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : {2'b0, w_reg};
    assign h9 = (h_reg == 7'd0) ? 9'd1
              : ({2'b0, h_reg} > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : {2'b0, h_reg};
    assign tw_prod = 17'(w9) * 17'd205;
    assign th_prod = 17'(h9) * 17'd205;
    assign tw9 = 9'(tw_prod >> 11);
    assign th9 = 9'(th_prod >> 11);
    assign x9 = 9'(x_reg);
    assign y9 = 9'(y_reg);
    assign cx9 = {3'b0, cell_x};
    assign cy9 = {3'b0, cell_y};
    assign multi = (w9 > 9'd1) && (h9 > 9'd1);
    assign x_last = x9 == w9 - 9'd1;
    assign y_last = y9 == h9 - 9'd1;
    assign centre = (dx_reg == 2'd1) && (dy_reg == 2'd1);
    assign k_last = (dx_reg == 2'd2) && (dy_reg == 2'd2);
    assign nx = x_reg + XW'(dx_reg) - XW'(1);
    assign ny = y_reg + YW'(dy_reg) - YW'(1);
    assign nbr_ok = centre || (multi
                    && !(dx_reg == 2'd0 && x_reg == '0)
                    && !(dy_reg == 2'd0 && y_reg == '0)
                    && !(dx_reg == 2'd2 && x9 + 9'd1 >= w9)
                    && !(dy_reg == 2'd2 && y9 + 9'd1 >= h9));
    assign in_acc = in_valid && !in_stall;
    assign in_stall = state_reg != ffa_pkg::ST_IDLE;
    assign seed_load = cfg_we && (cfg_index == ffa_pkg::CFG_SEED);

    always_comb
    begin
        case (pat_reg)
            ffa_pkg::PAT_ASH:    fill_val = ffa_pkg::CELL_ASH;
            ffa_pkg::PAT_YOUNG:  fill_val = ffa_pkg::CELL_YOUNG;
            ffa_pkg::PAT_CORNER: fill_val = (x_reg == '0 && y_reg == '0)
                                 ? ffa_pkg::CELL_IGNITE : ffa_pkg::CELL_YOUNG;
            default:             fill_val = (x9 <= tw9 && y9 <= th9)
                                 ? ffa_pkg::CELL_IGNITE : ffa_pkg::CELL_YOUNG;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        w_next = w_reg;
        h_next = h_reg;
        bank_next = bank_reg;
        x_next = x_reg;
        y_next = y_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        req_next = req_reg;
        pat_next = pat_reg;
        val_next = val_reg;
        centre_next = centre_reg;
        olds_next = olds_reg;
        nbr_next = nbr_reg;
        res_state_next = res_state_reg;
        res_status_next = res_status_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_state_next = out_state_reg;
        out_status_next = out_status_reg;
        raddr = {bank_reg, AW'(0)};
        waddr = {bank_reg, AW'(0)};
        we = 1'b0;
        wdata = fill_val;
        rule_start = 1'b0;

        if (cfg_we && cfg_index == ffa_pkg::CFG_WIDTH)
        begin
            w_next = cfg_data[6:0];
        end
        if (cfg_we && cfg_index == ffa_pkg::CFG_HEIGHT)
        begin
            h_next = cfg_data[6:0];
        end

        case (state_reg)
            ffa_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    req_next = req_type;
                    pat_next = fill_pattern;
                    val_next = (cell_value > ffa_pkg::CELL_DYING) ? ffa_pkg::CELL_DYING
                                                                  : cell_value;
                    res_state_next = ffa_pkg::CELL_ASH;
                    res_status_next = 1'b0;
                    x_next = '0;
                    y_next = '0;
                    dx_next = 2'd0;
                    dy_next = 2'd0;
                    olds_next = 4'd0;
                    nbr_next = '0;
                    case (req_type)
                        ffa_pkg::REQ_FILL:
                        begin
                            state_next = ffa_pkg::ST_FILL;
                        end
                        ffa_pkg::REQ_WRITE, ffa_pkg::REQ_READ:
                        begin
                            state_next = ffa_pkg::ST_ACCESS;
                            res_status_next = (cx9 >= w9) || (cy9 >= h9);
                            x_next = XW'(cell_x);
                            y_next = YW'(cell_y);
                        end
                        default:
                        begin
                            state_next = ffa_pkg::ST_GEN_RD;
                        end
                    endcase
                end
            end
            ffa_pkg::ST_FILL:
            begin
                we = 1'b1;
                waddr = (AW + 1)'(AW'(x_reg) * AW'(MAX_HEIGHT) + AW'(y_reg))
                      + (bank_reg ? (AW + 1)'(DEPTH) : '0);
                if (y_last)
                begin
                    y_next = '0;
                    x_next = x_reg + XW'(1);
                    if (x_last)
                    begin
                        state_next = ffa_pkg::ST_RESP;
                    end
                end
                else
                begin
                    y_next = y_reg + YW'(1);
                end
            end
            ffa_pkg::ST_ACCESS:
            begin
                raddr = (AW + 1)'(AW'(x_reg) * AW'(MAX_HEIGHT) + AW'(y_reg))
                      + (bank_reg ? (AW + 1)'(DEPTH) : '0);
                waddr = raddr;
                wdata = val_reg;
                if (res_status_reg || req_reg == ffa_pkg::REQ_WRITE)
                begin
                    we = !res_status_reg;
                    state_next = ffa_pkg::ST_RESP;
                end
                else
                begin
                    state_next = ffa_pkg::ST_ACC_CAP;
                end
            end
            ffa_pkg::ST_ACC_CAP:
            begin
                res_state_next = rdata_reg;
                state_next = ffa_pkg::ST_RESP;
            end
            ffa_pkg::ST_GEN_RD:
            begin
                raddr = (AW + 1)'(AW'(nx) * AW'(MAX_HEIGHT) + AW'(ny))
                      + (bank_reg ? (AW + 1)'(DEPTH) : '0);
                state_next = ffa_pkg::ST_GEN_CAP;
            end
            ffa_pkg::ST_GEN_CAP:
            begin
                if (centre)
                begin
                    centre_next = rdata_reg;
                end
                else if (nbr_ok)
                begin
                    case (rdata_reg)
                        ffa_pkg::CELL_IGNITE: nbr_next.ign = 1'b1;
                        ffa_pkg::CELL_BURN:   nbr_next.burn = 1'b1;
                        ffa_pkg::CELL_DYING:  nbr_next.dying = 1'b1;
                        ffa_pkg::CELL_OLD:    olds_next = olds_reg + 4'd1;
                        default:              olds_next = olds_reg;
                    endcase
                end
                if (k_last)
                begin
                    state_next = ffa_pkg::ST_GEN_START;
                end
                else
                begin
                    state_next = ffa_pkg::ST_GEN_RD;
                    if (dy_reg == 2'd2)
                    begin
                        dy_next = 2'd0;
                        dx_next = dx_reg + 2'd1;
                    end
                    else
                    begin
                        dy_next = dy_reg + 2'd1;
                    end
                end
            end
            ffa_pkg::ST_GEN_START:
            begin
                rule_start = 1'b1;
                state_next = ffa_pkg::ST_GEN_WAIT;
            end
            ffa_pkg::ST_GEN_WAIT:
            begin
                waddr = (AW + 1)'(AW'(x_reg) * AW'(MAX_HEIGHT) + AW'(y_reg))
                      + (bank_reg ? '0 : (AW + 1)'(DEPTH));
                wdata = rule_result;
                if (rule_done)
                begin
                    we = 1'b1;
                    dx_next = 2'd0;
                    dy_next = 2'd0;
                    olds_next = 4'd0;
                    nbr_next = '0;
                    state_next = ffa_pkg::ST_GEN_RD;
                    if (y_last)
                    begin
                        y_next = '0;
                        x_next = x_reg + XW'(1);
                        if (x_last)
                        begin
                            bank_next = !bank_reg;
                            state_next = ffa_pkg::ST_RESP;
                        end
                    end
                    else
                    begin
                        y_next = y_reg + YW'(1);
                    end
                end
            end
            ffa_pkg::ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_state_next = res_state_reg;
                    out_status_next = res_status_reg;
                    state_next = ffa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffa_pkg::ST_IDLE;
            end
        endcase
        nbr_next.old5 = olds_next >= 4'd5;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffa_pkg::ST_IDLE;
            w_reg <= 7'd64;
            h_reg <= 7'd64;
            bank_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            w_reg <= w_next;
            h_reg <= h_next;
            bank_reg <= bank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        req_reg <= req_next;
        pat_reg <= pat_next;
        val_reg <= val_next;
        centre_reg <= centre_next;
        olds_reg <= olds_next;
        nbr_reg <= nbr_next;
        res_state_reg <= res_state_next;
        res_status_reg <= res_status_next;
        out_state_reg <= out_state_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    ffa_rule_unit u_rule
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed_load   (seed_load),
        .seed_value  (cfg_data),
        .start       (rule_start),
        .centre_cell (centre_reg),
        .nbr         (nbr_reg),
        .done        (rule_done),
        .result      (rule_result)
    );

    assign out_valid = out_valid_reg;
    assign cell_state = out_state_reg;
    assign status = out_status_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rule_done |-> state_reg == ffa_pkg::ST_GEN_WAIT)
        else $error("rule result outside a generation");
    a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
        bank_reg != $past(bank_reg) |-> $past(state_reg) == ffa_pkg::ST_GEN_WAIT)
        else $error("bank swapped outside a generation");
    a_resp_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffa_pkg::ST_IDLE && $past(state_reg) != ffa_pkg::ST_IDLE
        |-> out_valid_reg)
        else $error("request finished without a result word");

endmodule

// ----- tb/sv/forest_fire_automaton_engine_test.sv -----
`timescale 1ns / 1ps

module forest_fire_automaton_engine_test;

    localparam int GRID_SIDE = 64;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int PHASE_ITEMS = 10;

    class fire_scoreboard;
        bit [2:0] cells [2][GRID_SIDE*GRID_SIDE];
        bit known [2][GRID_SIDE*GRID_SIDE];
        bit cur;
        bit [31:0] lfsr;
        bit [6:0] width_reg;
        bit [6:0] height_reg;
        bit [2:0] state_q[$];
        bit status_q[$];
        int errors;
        int checked;
        int generations;

        function new();
            width_reg = 7'd64;
            height_reg = 7'd64;
            lfsr = 32'd1;
        endfunction

        function int dim(bit [6:0] v);
            if (v == 0) return 1;
            return (v > GRID_SIDE) ? GRID_SIDE : int'(v);
        endfunction

        function int cols();
            return dim(width_reg);
        endfunction

        function int rows();
            return dim(height_reg);
        endfunction

        function void configure(bit [1:0] index, bit [31:0] data);
            case (index)
                ffa_pkg::CFG_WIDTH: width_reg = data[6:0];
                ffa_pkg::CFG_HEIGHT: height_reg = data[6:0];
                ffa_pkg::CFG_SEED: lfsr = (data == 0) ? 32'd1 : data;
                default: ;
            endcase
        endfunction

        function bit cell_known(int x, int y);
            return known[cur][x*GRID_SIDE + y];
        endfunction

        function bit region_known();
            for (int x = 0; x < cols(); x++)
                for (int y = 0; y < rows(); y++)
                    if (!known[cur][x*GRID_SIDE + y]) return 0;
            return 1;
        endfunction

        function bit roll(int n);
            bit lsb;
            bit [31:0] limit;
            lsb = lfsr[0];
            limit = 32'((64'd1 << 32) / n);
            lfsr = (lfsr >> 1) ^ (lsb ? ffa_pkg::LFSR_MASK : 32'd0);
            return lfsr < limit;
        endfunction

        function bit [2:0] evolve(int x, int y);
            bit ign, burn, dying;
            int olds, nx, ny;
            bit [2:0] s, c;
            ign = 0;
            burn = 0;
            dying = 0;
            olds = 0;
            c = cells[cur][x*GRID_SIDE + y];
            if (cols() > 1 && rows() > 1) begin
                for (int dx = -1; dx <= 1; dx++) begin
                    for (int dy = -1; dy <= 1; dy++) begin
                        nx = x + dx;
                        ny = y + dy;
                        if ((dx == 0 && dy == 0) || nx < 0 || ny < 0 || nx >= cols()
                            || ny >= rows()) continue;
                        s = cells[cur][nx*GRID_SIDE + ny];
                        if (s == ffa_pkg::CELL_IGNITE) ign = 1;
                        else if (s == ffa_pkg::CELL_BURN) burn = 1;
                        else if (s == ffa_pkg::CELL_DYING) dying = 1;
                        else if (s == ffa_pkg::CELL_OLD) olds++;
                    end
                end
            end
            case (c)
                ffa_pkg::CELL_YOUNG:
                begin
                    if (ign && roll(100)) return ffa_pkg::CELL_IGNITE;
                    if (burn && roll(50)) return ffa_pkg::CELL_IGNITE;
                    if (dying && roll(100)) return ffa_pkg::CELL_IGNITE;
                    if (roll(200)) return ffa_pkg::CELL_OLD;
                    return ffa_pkg::CELL_YOUNG;
                end
                ffa_pkg::CELL_OLD:
                begin
                    if (ign && roll(10)) return ffa_pkg::CELL_IGNITE;
                    if (burn && roll(5)) return ffa_pkg::CELL_IGNITE;
                    if (dying && roll(10)) return ffa_pkg::CELL_IGNITE;
                    if (olds >= 5 && roll(20000)) return ffa_pkg::CELL_IGNITE;
                    return ffa_pkg::CELL_OLD;
                end
                ffa_pkg::CELL_IGNITE:
                    return roll(10) ? ffa_pkg::CELL_BURN : ffa_pkg::CELL_IGNITE;
                ffa_pkg::CELL_BURN:
                    return roll(10) ? ffa_pkg::CELL_DYING : ffa_pkg::CELL_BURN;
                ffa_pkg::CELL_DYING:
                    return roll(10) ? ffa_pkg::CELL_ASH : ffa_pkg::CELL_DYING;
                default: return roll(1000) ? ffa_pkg::CELL_YOUNG : ffa_pkg::CELL_ASH;
            endcase
        endfunction

        function void note_input(bit [1:0] req, bit [5:0] x, bit [5:0] y, bit [2:0] v,
                                 bit [1:0] pat);
            bit [2:0] st;
            bit stat;
            bit [2:0] fillv;
            int w, h;
            st = ffa_pkg::CELL_ASH;
            stat = 0;
            w = cols();
            h = rows();
            case (req)
                ffa_pkg::REQ_FILL:
                begin
                    for (int i = 0; i < w; i++) begin
                        for (int j = 0; j < h; j++) begin
                            if (pat == ffa_pkg::PAT_ASH) fillv = ffa_pkg::CELL_ASH;
                            else if (pat == ffa_pkg::PAT_YOUNG) fillv = ffa_pkg::CELL_YOUNG;
                            else if (pat == ffa_pkg::PAT_CORNER)
                                fillv = (i == 0 && j == 0) ? ffa_pkg::CELL_IGNITE
                                                           : ffa_pkg::CELL_YOUNG;
                            else
                                fillv = (i <= w / 10 && j <= h / 10) ? ffa_pkg::CELL_IGNITE
                                                                     : ffa_pkg::CELL_YOUNG;
                            cells[cur][i*GRID_SIDE + j] = fillv;
                            known[cur][i*GRID_SIDE + j] = 1;
                        end
                    end
                end
                ffa_pkg::REQ_WRITE, ffa_pkg::REQ_READ:
                begin
                    if (x >= w || y >= h) stat = 1;
                    else if (req == ffa_pkg::REQ_WRITE) begin
                        cells[cur][x*GRID_SIDE + y] = (v > ffa_pkg::CELL_DYING)
                                                      ? ffa_pkg::CELL_DYING : v;
                        known[cur][x*GRID_SIDE + y] = 1;
                    end
                    else st = cells[cur][x*GRID_SIDE + y];
                end
                default:
                begin
                    for (int i = 0; i < w; i++) begin
                        for (int j = 0; j < h; j++) begin
                            cells[!cur][i*GRID_SIDE + j] = evolve(i, j);
                            known[!cur][i*GRID_SIDE + j] = 1;
                        end
                    end
                    cur = !cur;
                    generations++;
                end
            endcase
            state_q = {state_q, st};
            status_q = {status_q, stat};
        endfunction

        function void check(bit [2:0] st, bit stat);
            bit [2:0] want_st;
            bit want_stat;
            if (state_q.size() == 0) begin
                $display("%0t: unexpected word, cell_state %0d status %0d", $time, st, stat);
                errors++;
                return;
            end
            want_st = state_q.pop_front();
            want_stat = status_q.pop_front();
            checked++;
            if (st !== want_st) begin
                $display("%0t: cell_state expected %0d actual %0d", $time, want_st, st);
                errors++;
            end
            if (stat !== want_stat) begin
                $display("%0t: status expected %0d actual %0d", $time, want_stat, stat);
                errors++;
            end
        endfunction

        function int pending();
            return state_q.size();
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = 0;
    logic [31:0] cfg_data = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  req_type = 0;
    logic [5:0]  cell_x = 0;
    logic [5:0]  cell_y = 0;
    logic [2:0]  cell_value = 0;
    logic [1:0]  fill_pattern = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [2:0]  cell_state;
    logic [0:0]  status;

    fire_scoreboard sb = new();
    int sent = 0;
    int settings = 0;
    int burst_left = 1;
    int stall_mode = 0;
    bit hold = 0;
    int cycles = 0;

    forest_fire_automaton_engine u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .cell_x(cell_x),
        .cell_y(cell_y),
        .cell_value(cell_value),
        .fill_pattern(fill_pattern),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cell_state(cell_state),
        .status(status)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("[forest_fire_automaton_engine] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check(cell_state, status);
        if (stall_mode == 1) out_stall <= hold || ($urandom_range(99) < 30);
        else if (stall_mode == 2) out_stall <= hold || ($urandom_range(99) < 70);
        else out_stall <= hold;
        if ($urandom_range(63) == 0) stall_mode = $urandom_range(2);
    end

    initial
    begin
        wait (sent >= 70);
        hold = 1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold = 0;
    end

    task automatic push(logic [1:0] req, logic [5:0] x, logic [5:0] y, logic [2:0] v,
                        logic [1:0] pat);
        int gap;
        in_valid <= 1;
        req_type <= req;
        cell_x <= x;
        cell_y <= y;
        cell_value <= v;
        fill_pattern <= pat;
        do @(posedge clk); while (in_stall);
        sb.note_input(req, x, y, v, pat);
        sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                in_valid <= 0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic cfg_write(logic [1:0] index, logic [31:0] data);
        cfg_we <= 1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        sb.configure(index, data);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_grid(logic [31:0] w, logic [31:0] h, logic [31:0] seed);
        drain();
        cfg_write(ffa_pkg::CFG_WIDTH, w);
        cfg_write(ffa_pkg::CFG_HEIGHT, h);
        cfg_write(ffa_pkg::CFG_SEED, seed);
        cfg_we <= 0;
        settings++;
    endtask

    task automatic random_item();
        int r, w, h;
        logic [1:0] req;
        logic [5:0] x, y;
        w = sb.cols();
        h = sb.rows();
        r = $urandom_range(99);
        req = (r < 10) ? ffa_pkg::REQ_FILL : (r < 45) ? ffa_pkg::REQ_WRITE
            : (r < 80) ? ffa_pkg::REQ_READ : ffa_pkg::REQ_ADVANCE;
        if ($urandom_range(7) == 0) begin
            x = 6'($urandom_range(63));
            y = 6'($urandom_range(63));
        end
        else begin
            x = 6'($urandom_range(w - 1));
            y = 6'($urandom_range(h - 1));
        end
        if (req == ffa_pkg::REQ_READ && x < w && y < h && !sb.cell_known(x, y))
            req = ffa_pkg::REQ_WRITE;
        if (req == ffa_pkg::REQ_ADVANCE && !sb.region_known()) req = ffa_pkg::REQ_FILL;
        push(req, x, y, 3'($urandom_range(7)), 2'($urandom_range(3)));
    endtask

    initial
    begin
        int pw [10] = '{1, 0, 7, 127, 3, 8, 5, 12, 1, 64};
        int ph [10] = '{1, 9, 1, 3, 200, 8, 5, 6, 64, 1};
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        push(ffa_pkg::REQ_FILL, 0, 0, 0, ffa_pkg::PAT_TENTH);
        push(ffa_pkg::REQ_READ, 6, 6, 0, 0);
        push(ffa_pkg::REQ_READ, 7, 7, 0, 0);
        push(ffa_pkg::REQ_WRITE, 63, 63, 7, 0);
        push(ffa_pkg::REQ_READ, 63, 63, 0, 0);
        push(ffa_pkg::REQ_WRITE, 0, 63, 6, 0);
        push(ffa_pkg::REQ_ADVANCE, 0, 0, 0, 0);
        push(ffa_pkg::REQ_READ, 0, 0, 0, 0);
        push(ffa_pkg::REQ_READ, 63, 63, 0, 0);
        push(ffa_pkg::REQ_FILL, 0, 0, 0, ffa_pkg::PAT_CORNER);
        push(ffa_pkg::REQ_READ, 0, 0, 0, 0);
        push(ffa_pkg::REQ_FILL, 0, 0, 0, ffa_pkg::PAT_YOUNG);
        push(ffa_pkg::REQ_FILL, 0, 0, 0, ffa_pkg::PAT_ASH);
        push(ffa_pkg::REQ_READ, 31, 17, 0, 0);

        set_grid(5, 4, 0);
        push(ffa_pkg::REQ_FILL, 0, 0, 0, ffa_pkg::PAT_YOUNG);
        push(ffa_pkg::REQ_WRITE, 5, 0, 3, 0);
        push(ffa_pkg::REQ_WRITE, 0, 4, 3, 0);
        push(ffa_pkg::REQ_READ, 63, 63, 0, 0);
        push(ffa_pkg::REQ_WRITE, 4, 3, 2, 0);
        push(ffa_pkg::REQ_READ, 4, 3, 0, 0);
        push(ffa_pkg::REQ_WRITE, 2, 2, 4, 0);
        push(ffa_pkg::REQ_ADVANCE, 0, 0, 0, 0);
        push(ffa_pkg::REQ_ADVANCE, 0, 0, 0, 0);
        push(ffa_pkg::REQ_READ, 2, 2, 0, 0);

        for (int p = 0; p < 10; p++) begin
            set_grid(pw[p], ph[p], (p == 3) ? 32'hFFFF_FFFF : $urandom());
            push(ffa_pkg::REQ_FILL, 0, 0, 0, 2'($urandom_range(3)));
            for (int i = 0; i < PHASE_ITEMS; i++) random_item();
        end

        set_grid($urandom_range(2, 16), $urandom_range(2, 16), $urandom());
        push(ffa_pkg::REQ_FILL, 0, 0, 0, ffa_pkg::PAT_TENTH);
        repeat (PHASE_ITEMS) random_item();

        drain();
        $display("Covered %0d requests over %0d grid settings, %0d generations advanced.",
                 sent, settings, sb.generations);
        $display("Checked %0d result words, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[forest_fire_automaton_engine] OK");
        else
            $display("[forest_fire_automaton_engine] ERROR");
        $finish;
    end

endmodule
